// ===== design/asmv_pkg.sv =====
// Shared types, constants and GF(2^128) digit step for the MAC share verifier.
`timescale 1ns / 1ps

package asmv_pkg;

  localparam int unsigned FieldW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned DigitW  = 16;
  localparam int unsigned NSteps  = FieldW / DigitW;
  localparam int unsigned CntW    = $clog2(NSteps);
  localparam int unsigned AddrW   = 5;
  localparam int unsigned RedW    = DigitW + 7;

  // register index taken from paddr[4:3]
  localparam logic [1:0] RegKeyLo = 2'd0;
  localparam logic [1:0] RegKeyHi = 2'd1;
  localparam logic [1:0] RegMode  = 2'd2;

  localparam logic ModePerElement = 1'b0;
  localparam logic ModeBatched    = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_FIN  = 6'b001000,
    S_CHK  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

  // acc * x^16 + a * dig, reduced by x^128 + x^7 + x^2 + x + 1
  function automatic logic [FieldW-1:0] gf_digit_step(
    input logic [FieldW-1:0] acc,
    input logic [FieldW-1:0] a,
    input logic [DigitW-1:0] dig
  );
    logic [FieldW+DigitW-1:0] w;
    logic [DigitW-1:0]        hi;
    logic [RedW-1:0]          hx;
    logic [RedW-1:0]          rd;
    w = {acc, {DigitW{1'b0}}};
    for (int i = 0; i < DigitW; i++) begin
      if (dig[i]) begin
        w = w ^ ({{DigitW{1'b0}}, a} << i);
      end
    end
    hi = w[FieldW+DigitW-1:FieldW];
    hx = {7'b0, hi};
    rd = (hx << 7) ^ (hx << 2) ^ (hx << 1) ^ hx;
    return w[FieldW-1:0] ^ {{(FieldW-RedW){1'b0}}, rd};
  endfunction

endpackage

// ===== design/auth_share_mac_verifier_top.sv =====
// Top level of the GF(2^128) MAC share verifier: config port, sequencer, accumulators.
`timescale 1ns / 1ps

// Use:
//   Input channel (in_valid_i / in_stall_o) carries one element word: both
//   parties' data and tag shares, a challenge and last_element. Output
//   channel (out_valid_o / out_stall_i) carries one verdict word per run,
//   shares_valid_o = 1 when the run verifies.
//   Each element runs through three 16-bit digit-serial GF(2^128)
//   multipliers in parallel: accept, 8 digit steps and an accumulate step.
//   The input stalls until the element is through, so no new word is taken
//   while one is in flight; a closing word also holds the input until its
//   verdict is moved to the output register. In batched mode the verdict
//   follows one more 8-step multiply of the key by the data sum plus a
//   compare step; in per-element mode it is formed at the accumulate step.
//   Sums and the mismatch flag clear by the time the verdict is formed.
//   Reset clears the key, selects batched mode, clears the sums and leaves
//   the block idle. The verdict sits in an output register; a new element
//   is taken while it waits. If the receiver stalls and a second verdict is
//   ready, the block holds it and stalls its input until the first leaves.
//   Config: APB, registers at 0x00 key low, 0x08 key high, 0x10 mode.
//   Write config only while idle.

module auth_share_mac_verifier_top import asmv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [HalfW-1:0]  pwdata,
  output logic [HalfW-1:0]  prdata,
  output logic              pready,
  // element input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [HalfW-1:0]  share1_data_lo_i,
  input  logic [HalfW-1:0]  share1_data_hi_i,
  input  logic [HalfW-1:0]  share1_tag_lo_i,
  input  logic [HalfW-1:0]  share1_tag_hi_i,
  input  logic [HalfW-1:0]  share2_data_lo_i,
  input  logic [HalfW-1:0]  share2_data_hi_i,
  input  logic [HalfW-1:0]  share2_tag_lo_i,
  input  logic [HalfW-1:0]  share2_tag_hi_i,
  input  logic [HalfW-1:0]  challenge_lo_i,
  input  logic [HalfW-1:0]  challenge_hi_i,
  input  logic              last_element_i,
  // verdict output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              shares_valid_o
);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [HalfW-1:0]  key_lo_q, key_hi_q;
  logic              mode_q;
  logic [FieldW-1:0] t_q, t_d;
  logic [FieldW-1:0] tag_sum_q, tag_sum_d;
  logic [FieldW-1:0] data_sum_q, data_sum_d;
  logic              mismatch_q, mismatch_d;
  logic              last_q, last_d;
  logic              verdict_q, verdict_d;
  logic              out_valid_q, out_valid_d;
  logic              out_data_q, out_data_d;

  logic              in_acc;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic [FieldW-1:0] key, d_in, t_in, c_in;
  logic [FieldW-1:0] p0, p1, p2;
  logic [FieldW-1:0] tag_nx, data_nx;
  logic              mism_nx;
  logic [FieldW-1:0] m0_b;
  mul_ctrl_t         m0_ctrl, m12_ctrl;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      RegKeyLo: prdata = key_lo_q;
      RegKeyHi: prdata = key_hi_q;
      RegMode:  prdata = {{(HalfW-1){1'b0}}, mode_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      mode_q   <= ModeBatched;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegKeyLo: key_lo_q <= pwdata;
        RegKeyHi: key_hi_q <= pwdata;
        RegMode:  mode_q   <= pwdata[0];
        default:  ;
      endcase
    end
  end

  // operands
  assign key  = {key_hi_q, key_lo_q};
  assign d_in = {share1_data_hi_i ^ share2_data_hi_i, share1_data_lo_i ^ share2_data_lo_i};
  assign t_in = {share1_tag_hi_i ^ share2_tag_hi_i, share1_tag_lo_i ^ share2_tag_lo_i};
  assign c_in = {challenge_hi_i, challenge_lo_i};

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign mism_nx = mismatch_q | (p0 != t_q);
  assign tag_nx  = tag_sum_q ^ p1;
  assign data_nx = data_sum_q ^ p2;

  // key multiplier: per-element check, then, in batched mode, the final key * data sum
  assign m0_b          = (state_q == S_ACC) ? data_nx : d_in;
  assign m0_ctrl.load  = in_acc || (state_q == S_ACC && last_q && mode_q == ModeBatched);
  assign m0_ctrl.step  = (state_q == S_MUL) || (state_q == S_FIN);
  assign m12_ctrl.load = in_acc;
  assign m12_ctrl.step = (state_q == S_MUL);

  asmv_gfmul u_mul_key (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (m0_ctrl),
    .a_i    (key),
    .b_i    (m0_b),
    .p_o    (p0)
  );

  asmv_gfmul u_mul_tag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (m12_ctrl),
    .a_i    (c_in),
    .b_i    (t_in),
    .p_o    (p1)
  );

  asmv_gfmul u_mul_data (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (m12_ctrl),
    .a_i    (c_in),
    .b_i    (d_in),
    .p_o    (p2)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    tag_sum_d   = tag_sum_q;
    data_sum_d  = data_sum_q;
    mismatch_d  = mismatch_q;
    last_d      = last_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          t_d     = t_in;
          last_d  = last_element_i;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NSteps - 1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (!last_q) begin
          tag_sum_d  = tag_nx;
          data_sum_d = data_nx;
          mismatch_d = mism_nx;
          state_d    = S_IDLE;
        end else if (mode_q == ModeBatched) begin
          // hold the tag sum for the final compare
          tag_sum_d  = tag_nx;
          data_sum_d = '0;
          mismatch_d = 1'b0;
          cnt_d      = '0;
          state_d    = S_FIN;
        end else begin
          verdict_d  = !mism_nx;
          tag_sum_d  = '0;
          data_sum_d = '0;
          mismatch_d = 1'b0;
          state_d    = S_OUT;
        end
      end
      S_FIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NSteps - 1)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        verdict_d = (p0 == tag_sum_q);
        tag_sum_d = '0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = verdict_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tag_sum_q   <= '0;
      data_sum_q  <= '0;
      mismatch_q  <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tag_sum_q   <= tag_sum_d;
      data_sum_q  <= data_sum_d;
      mismatch_q  <= mismatch_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    verdict_q  <= verdict_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign shares_valid_o = out_data_q;

endmodule

// ===== design/asmv_gfmul.sv =====
// Digit-serial GF(2^128) multiplier, one 16-bit digit of b per step, MSB digit first.
`timescale 1ns / 1ps

module asmv_gfmul import asmv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_ctrl_t         ctrl_i,
  input  logic [FieldW-1:0] a_i,
  input  logic [FieldW-1:0] b_i,
  output logic [FieldW-1:0] p_o
);

  logic [FieldW-1:0] a_q, a_d;
  logic [FieldW-1:0] b_q, b_d;
  logic [FieldW-1:0] acc_q, acc_d;
  logic              busy_q, busy_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    busy_d = busy_q;
    if (ctrl_i.load) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      busy_d = 1'b1;
    end else if (ctrl_i.step && busy_q) begin
      acc_d = gf_digit_step(acc_q, a_q, b_q[FieldW-1 -: DigitW]);
      b_d   = b_q << DigitW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign p_o = acc_q;

endmodule

// ===== design/asmv_checker.sv =====
// Port-level checker for the MAC share verifier and its bind to the top level.
`timescale 1ns / 1ps

module asmv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic shares_valid_o
);

  // a stalled verdict word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shares_valid_o))
    else $error("verdict dropped or changed while stalled");

  // one element at a time: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an element is in flight");

  // a verdict never appears the cycle after an element is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("verdict raised too early after input");

  // a verdict is released only after the block was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("verdict raised without work in flight");

endmodule

bind auth_share_mac_verifier_top asmv_checker u_asmv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .shares_valid_o (shares_valid_o)
);
